@@ src/salwbc_pkg.sv @@
// ----------------------------------------------------------------------------
// salwbc_pkg
// Shared types and constants of the set-associative write-back cache unit.
// ----------------------------------------------------------------------------
`default_nettype none

package salwbc_pkg;

  localparam int BLOCK_W    = 30;
  localparam int TDATA_W    = 32;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int WAYS_REG_W = 4;

  // divider walks the padded block number one digit per cycle
  localparam int DIV_W      = 32;
  localparam int DIV_DIGIT  = 4;
  localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_WAYS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETS = 1'd1;

  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_WRITEBACK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOOK,
    S_UPDATE,
    S_EMIT_WB,
    S_EMIT_LD
  } salwbc_state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic look;
    logic update;
    logic emit_wb;
    logic emit_ld;
  } salwbc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic is_hit;
    logic need_wb;
    logic out_free;
  } salwbc_status_t;

endpackage

`default_nettype wire

@@ src/salwbc_ram.sv @@
// ----------------------------------------------------------------------------
// salwbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module salwbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/salwbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// salwbc_ctrl
// Access sequencer: divide, read set, decide, write back set, emit results.
// ----------------------------------------------------------------------------
`default_nettype none

module salwbc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire salwbc_pkg::salwbc_status_t status,
  output salwbc_pkg::salwbc_cmd_t      cmd
);

  import salwbc_pkg::*;

  salwbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_nxt = S_READ;
      end
      S_READ:   state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_UPDATE;
      S_UPDATE: begin
        if (status.is_hit) begin
          state_nxt = S_IDLE;
        end else if (status.need_wb) begin
          state_nxt = S_EMIT_WB;
        end else begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_WB: begin
        if (status.out_free) state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      S_DIV:     cmd.div_step = 1'b1;
      S_READ:    ;
      S_LOOK:    cmd.look = 1'b1;
      S_UPDATE:  cmd.update = 1'b1;
      S_EMIT_WB: cmd.emit_wb = status.out_free;
      S_EMIT_LD: cmd.emit_ld = status.out_free;
      default:   ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/salwbc_datapath.sv @@
// ----------------------------------------------------------------------------
// salwbc_datapath
// Set index divider, per-set tag and state rows, LRU update, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module salwbc_datapath #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [salwbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [salwbc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                  in_req,
  input  wire logic [salwbc_pkg::BLOCK_W-1:0]        in_block,
  input  wire salwbc_pkg::salwbc_cmd_t               cmd,
  output salwbc_pkg::salwbc_status_t                 status,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic                                       out_tuser,
  output logic [salwbc_pkg::BLOCK_W-1:0]             out_block,
  output logic                                       out_tlast
);

  import salwbc_pkg::*;

  localparam int WCW = $clog2(MAX_WAYS + 1);
  localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SCW = $clog2(MAX_SETS + 1);
  localparam int MW  = $clog2(MAX_SETS) + 1;
  localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int ME  = AGW + 2;
  localparam int TRW = MAX_WAYS * BLOCK_W;
  localparam int MRW = MAX_WAYS * ME;

  // configuration
  logic [WCW-1:0] ways_r;
  logic [SCW-1:0] sets_r;
  logic [MAX_SETS-1:0] row_ok_r;

  // access registers
  logic                 req_r;
  logic [BLOCK_W-1:0]   blk_r;
  logic [DIV_W-1:0]     sh_r;
  logic [WCW-1:0]       drem_r;
  logic [MW-1:0]        set_acc_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [WCW-1:0] rr  [DIV_DIGIT+1];
  logic [WCW:0]   r5a [DIV_DIGIT];
  logic [MW-1:0]  mm  [DIV_DIGIT+1];
  logic [MW:0]    m2a [DIV_DIGIT];
  logic           qb  [DIV_DIGIT];

  logic [SIW-1:0] set_idx;
  logic [TRW-1:0] tag_rd;
  logic [MRW-1:0] meta_rd;

  logic [TRW-1:0] tag_wr_r, tag_nxt;
  logic [MRW-1:0] meta_wr_r, meta_nxt;
  logic           hit_r, need_wb_r, hit_nxt, need_wb_nxt;
  logic [BLOCK_W-1:0] victim_r, victim_nxt;

  logic           v_a [MAX_WAYS];
  logic           d_a [MAX_WAYS];
  logic [AGW-1:0] a_a [MAX_WAYS];
  logic           row_ok;
  logic           free_found;
  logic [WIW-1:0] hit_w, free_w, lru_w, tgt_w;
  logic [AGW-1:0] ways_m1, thr;
  logic           inc_all;

  assign set_idx = set_acc_r[SIW-1:0];
  assign row_ok  = row_ok_r[set_idx];
  assign ways_m1 = AGW'(ways_r - WCW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r   <= WCW'(1);
      sets_r   <= SCW'(1);
      row_ok_r <= '0;
    end else if (cfg_we) begin
      row_ok_r <= '0;
      unique case (cfg_index)
        REG_WAYS: begin
          if (cfg_data[WAYS_REG_W-1:0] == '0) begin
            ways_r <= WCW'(1);
          end else if (32'(cfg_data[WAYS_REG_W-1:0]) > 32'(MAX_WAYS)) begin
            ways_r <= WCW'(MAX_WAYS);
          end else begin
            ways_r <= WCW'(cfg_data[WAYS_REG_W-1:0]);
          end
        end
        REG_SETS: begin
          if (cfg_data == '0) begin
            sets_r <= SCW'(1);
          end else if (32'(cfg_data) > 32'(MAX_SETS)) begin
            sets_r <= SCW'(MAX_SETS);
          end else begin
            sets_r <= SCW'(cfg_data);
          end
        end
        default: ;
      endcase
    end else if (cmd.update) begin
      row_ok_r[set_idx] <= 1'b1;
    end
  end

  // one digit of block / ways, each quotient bit folded at once into mod sets
  always_comb begin
    rr[0] = drem_r;
    mm[0] = set_acc_r;
    for (int k = 0; k < DIV_DIGIT; k++) begin
      r5a[k] = {rr[k], sh_r[DIV_W-1-k]};
      qb[k]  = (r5a[k] >= (WCW+1)'(ways_r));
      rr[k+1] = qb[k] ? WCW'(r5a[k] - (WCW+1)'(ways_r)) : WCW'(r5a[k]);
      m2a[k] = {mm[k], qb[k]};
      mm[k+1] = (m2a[k] >= (MW+1)'(sets_r)) ? MW'(m2a[k] - (MW+1)'(sets_r))
                                            : MW'(m2a[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r     <= in_req;
      blk_r     <= in_block;
      sh_r      <= DIV_W'(in_block);
      drem_r    <= '0;
      set_acc_r <= '0;
      cnt_r     <= '0;
    end else if (cmd.div_step) begin
      sh_r      <= sh_r << DIV_DIGIT;
      drem_r    <= rr[DIV_DIGIT];
      set_acc_r <= mm[DIV_DIGIT];
      cnt_r     <= cnt_r + DIV_CNT_W'(1);
    end
  end

  salwbc_ram #(.WIDTH(TRW), .DEPTH(MAX_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_idx),
    .wdata (tag_wr_r),
    .raddr (set_idx),
    .rdata (tag_rd)
  );

  salwbc_ram #(.WIDTH(MRW), .DEPTH(MAX_SETS)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_idx),
    .wdata (meta_wr_r),
    .raddr (set_idx),
    .rdata (meta_rd)
  );

  // lookup and replacement decision over the row just read
  always_comb begin
    hit_nxt    = 1'b0;
    free_found = 1'b0;
    hit_w      = '0;
    free_w     = '0;
    lru_w      = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      // a row not written since the last flush reads as all empty
      v_a[w] = row_ok & meta_rd[w*ME];
      d_a[w] = row_ok & meta_rd[w*ME+1];
      a_a[w] = row_ok ? meta_rd[w*ME+2 +: AGW] : '0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (32'(w) < 32'(ways_r)) begin
        if (v_a[w] && tag_rd[w*BLOCK_W +: BLOCK_W] == blk_r && !hit_nxt) begin
          hit_nxt = 1'b1;
          hit_w   = WIW'(w);
        end
        if (!v_a[w] && !free_found) begin
          free_found = 1'b1;
          free_w     = WIW'(w);
        end
        if (v_a[w] && a_a[w] == ways_m1) begin
          lru_w = WIW'(w);
        end
      end
    end
    tgt_w       = hit_nxt ? hit_w : (free_found ? free_w : lru_w);
    thr         = hit_nxt ? a_a[hit_w] : ways_m1;
    inc_all     = !hit_nxt && free_found;
    need_wb_nxt = !hit_nxt && !free_found && d_a[lru_w];
    victim_nxt  = tag_rd[lru_w*BLOCK_W +: BLOCK_W];
    tag_nxt     = tag_rd;
    meta_nxt    = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      meta_nxt[w*ME]            = v_a[w];
      meta_nxt[w*ME+1]          = d_a[w];
      meta_nxt[w*ME+2 +: AGW]   = (v_a[w] && (inc_all || a_a[w] < thr))
                                  ? a_a[w] + AGW'(1) : a_a[w];
      if (WIW'(w) == tgt_w) begin
        meta_nxt[w*ME]          = 1'b1;
        meta_nxt[w*ME+1]        = hit_nxt ? (d_a[w] | req_r) : req_r;
        meta_nxt[w*ME+2 +: AGW] = '0;
        if (!hit_nxt) tag_nxt[w*BLOCK_W +: BLOCK_W] = blk_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      tag_wr_r  <= tag_nxt;
      meta_wr_r <= meta_nxt;
      hit_r     <= hit_nxt;
      need_wb_r <= need_wb_nxt;
      victim_r  <= victim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.emit_wb || cmd.emit_ld) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wb) begin
      out_tuser <= ACT_WRITEBACK;
      out_block <= victim_r;
      out_tlast <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_tuser <= ACT_LOAD;
      out_block <= blk_r;
      out_tlast <= 1'b1;
    end
  end

  assign status.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.is_hit   = hit_r;
  assign status.need_wb  = need_wb_r;
  assign status.out_free = !out_tvalid || out_tready;

endmodule

`default_nettype wire

@@ src/set_assoc_lru_writeback_cache_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_unit
// Set-associative write-back cache directory with LRU replacement.
// ----------------------------------------------------------------------------
// One access at a time. A hit gives no result and a miss gives one or two
// results; the result side may stall an access. The set index divider
// walks the block number four bits a cycle through block / ways and mod
// sets, then the set's tag and state rows are read, a decision is made, the
// rows are written back and each result is held in the output register.
// Writing either configuration register flushes the cache at once, without
// write-backs.
`default_nettype none

module set_assoc_lru_writeback_cache_unit #(
  parameter int MAX_WAYS = 8,
  parameter int MAX_SETS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [salwbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [salwbc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [salwbc_pkg::TDATA_W-1:0]      in_tdata,   // block[29:0], zero pad
  input  wire logic                                in_tuser,   // req_type
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [salwbc_pkg::TDATA_W-1:0]           out_tdata,  // target_block[29:0], zero pad
  output logic                                     out_tuser,  // action
  output logic                                     out_tlast
);

  import salwbc_pkg::*;

  salwbc_cmd_t        cmd;
  salwbc_status_t     status;
  logic [BLOCK_W-1:0] out_block;

  assign cfg_ready = 1'b1;
  assign out_tdata = TDATA_W'(out_block);

  salwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  salwbc_datapath #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_req     (in_tuser),
    .in_block   (in_tdata[BLOCK_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_block  (out_block),
    .out_tlast  (out_tlast)
  );

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second access taken while one is in flight");

  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_WRITEBACK |-> !out_tlast)
    else $error("write-back marked as final result");

  a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_LOAD |-> out_tlast)
    else $error("load not marked as final result");

endmodule

`default_nettype wire

@@ test/set_assoc_lru_writeback_cache_unit_test.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_unit_test
// Self-checking bench for the set-associative write-back cache directory.
// Accesses are fed to an LRU directory predictor kept inside the bench. The
// loads and write-backs it predicts are compared, in order, with the block's
// result stream. The run steps through several way/set shapes, with random
// stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_writeback_cache_unit_test;
  import salwbc_pkg::*;

  localparam int N_WAYS  = 8;
  localparam int N_SETS  = 256;
  localparam int N_LINES = N_WAYS * N_SETS;
  localparam int SETTLE  = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic               action;
    logic [BLOCK_W-1:0] blk;
    logic               last;
  } mem_op_t;

  class lru_directory_model;
    int                 ways_used;
    int                 sets_used;
    logic [BLOCK_W-1:0] tag[N_LINES];
    bit                 valid[N_LINES];
    bit                 dirty[N_LINES];
    int                 age[N_LINES];
    mem_op_t            ops_due[$];
    int                 errors;

    function void flush();
      for (int i = 0; i < N_LINES; i++) begin
        valid[i] = 0;
        dirty[i] = 0;
        age[i] = 0;
      end
    endfunction

    function void reset_state();
      ways_used = 1;
      sets_used = 1;
      errors = 0;
      flush();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int v;
      if (idx == REG_WAYS) begin
        v = data[WAYS_REG_W-1:0];
        if (v == 0) v = 1;
        if (v > N_WAYS) v = N_WAYS;
        ways_used = v;
      end else begin
        v = data;
        if (v == 0) v = 1;
        if (v > N_SETS) v = N_SETS;
        sets_used = v;
      end
      flush();
    endfunction

    function void push_op(logic act, logic [BLOCK_W-1:0] b, logic lst);
      mem_op_t op;
      op.action = act;
      op.blk = b;
      op.last = lst;
      ops_due = {ops_due, op};
    endfunction

    function void note_access(logic is_write, logic [BLOCK_W-1:0] b);
      int base, hit, free_way, lru, lru_age, w, old;
      bit have_lru;
      base = ((b / ways_used) % sets_used) * N_WAYS;
      hit = -1;
      free_way = -1;
      lru = 0;
      lru_age = 0;
      have_lru = 0;
      for (int k = 0; k < ways_used; k++) begin
        if (valid[base+k]) begin
          if (tag[base+k] == b && hit < 0) hit = k;
          if (!have_lru || age[base+k] > lru_age) begin
            have_lru = 1;
            lru = k;
            lru_age = age[base+k];
          end
        end else if (free_way < 0) begin
          free_way = k;
        end
      end
      if (hit >= 0) begin
        old = age[base+hit];
        for (int k = 0; k < ways_used; k++)
          if (valid[base+k] && age[base+k] < old) age[base+k]++;
        age[base+hit] = 0;
        if (is_write) dirty[base+hit] = 1;
        return;
      end
      if (free_way >= 0) begin
        for (int k = 0; k < ways_used; k++)
          if (valid[base+k]) age[base+k]++;
        w = free_way;
      end else begin
        if (dirty[base+lru]) push_op(ACT_WRITEBACK, tag[base+lru], 1'b0);
        for (int k = 0; k < ways_used; k++)
          if (valid[base+k] && age[base+k] < lru_age) age[base+k]++;
        w = lru;
      end
      tag[base+w] = b;
      valid[base+w] = 1;
      dirty[base+w] = is_write;
      age[base+w] = 0;
      push_op(ACT_LOAD, b, 1'b1);
    endfunction

    function void check_result(logic act, logic [TDATA_W-1:0] data, logic lst);
      mem_op_t op;
      if (ops_due.size() == 0) begin
        $display("%0t: unexpected result act=%0b blk=%h last=%0b", $time, act, data, lst);
        errors++;
        return;
      end
      op = ops_due.pop_front();
      if (act !== op.action) begin
        $display("%0t: action exp %0b got %0b", $time, op.action, act);
        errors++;
      end
      if (data !== {{(TDATA_W-BLOCK_W){1'b0}}, op.blk}) begin
        $display("%0t: target_block exp %h got %h", $time, op.blk, data);
        errors++;
      end
      if (lst !== op.last) begin
        $display("%0t: last exp %0b got %0b", $time, op.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return ops_due.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [TDATA_W-1:0]      in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [TDATA_W-1:0]      out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;

  lru_directory_model directory = new();
  bit calm;
  int stall_left;
  int quiet_cycles;

  set_assoc_lru_writeback_cache_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random stall bursts until the calm part
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      directory.check_result(out_tuser, out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[set_assoc_lru_writeback_cache_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send_access(logic is_write, logic [BLOCK_W-1:0] b);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = is_write;
    in_tdata = {{(TDATA_W-BLOCK_W){1'b0}}, b};
    do @(posedge clk); while (!in_tready);
    directory.note_access(is_write, b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (directory.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    directory.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly blocks that collide in a few sets, some spread over the whole range
  function automatic logic [BLOCK_W-1:0] pick_block();
    int s, j, w, nsets;
    nsets = directory.sets_used < 3 ? directory.sets_used : 3;
    if ($urandom_range(0, 9) < 2) return BLOCK_W'($urandom());
    s = $urandom_range(0, nsets - 1);
    j = $urandom_range(0, 3);
    w = $urandom_range(0, directory.ways_used - 1);
    return BLOCK_W'((s + directory.sets_used * j) * directory.ways_used + w);
  endfunction

  int shape_ways[8] = '{8, 1, 0, 15, 4, 2, 8, 3};
  int shape_sets[8] = '{256, 1, 0, 511, 3, 5, 1, 256};

  initial begin
    rst_n = 1'b0;
    calm = 0;
    cfg_valid = 1'b0;
    cfg_index = REG_WAYS;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    directory.reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one line in total: fills, clean and dirty evictions, hits
    send_access(1'b0, 30'h0);
    send_access(1'b0, 30'h0);
    send_access(1'b1, 30'h3FFFFFFF);
    send_access(1'b0, 30'h3FFFFFFF);
    send_access(1'b0, 30'h5);
    send_access(1'b1, 30'h5);
    send_access(1'b0, 30'h2AAAAAAA);
    send_access(1'b1, 30'h15555555);
    send_access(1'b1, 30'h15555555);
    send_access(1'b0, 30'h0);
    drain();
    // two ways, LRU order after a refresh
    write_cfg(REG_WAYS, 9'd2);
    send_access(1'b1, 30'h0);
    send_access(1'b1, 30'h1);
    send_access(1'b0, 30'h0);
    send_access(1'b0, 30'h2);
    send_access(1'b0, 30'h3);
    send_access(1'b0, 30'h0);
    // flush on register write drops dirty lines silently
    drain();
    write_cfg(REG_SETS, 9'd1);
    send_access(1'b0, 30'h0);
    send_access(1'b0, 30'h1);
    send_access(1'b0, 30'h2);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_cfg(REG_WAYS, CFG_DATA_W'(shape_ways[ph]));
      write_cfg(REG_SETS, CFG_DATA_W'(shape_sets[ph]));
      if (ph == 7) calm = 1;
      for (int n = 0; n < 205; n++) begin
        if (n == 100) drain();
        send_access(1'($urandom_range(0, 1)), pick_block());
      end
    end

    drain();
    if (directory.errors == 0 && directory.pending() == 0) begin
      $display("[set_assoc_lru_writeback_cache_unit] OK");
    end else begin
      $display("[set_assoc_lru_writeback_cache_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
